>>> hdl/triangle_rigid_transform_top_macros.svh
// Assertion macros for the triangle transform block.
// Used by the RTL files that carry checks; no other dependencies.
`ifndef TRIANGLE_RIGID_TRANSFORM_TOP_MACROS_SVH
`define TRIANGLE_RIGID_TRANSFORM_TOP_MACROS_SVH
`define TRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> hdl/trt_pkg.sv
// Package for the triangle transform block: register indexes and shared types.
// No dependencies.
package trt_pkg;
	typedef enum logic [2:0] {
		REG_QUAT_W = 3'd0, REG_QUAT_X = 3'd1, REG_QUAT_Y = 3'd2, REG_QUAT_Z = 3'd3,
		REG_OFFSET_X = 3'd4, REG_OFFSET_Y = 3'd5, REG_OFFSET_Z = 3'd6,
		REG_SCALE = 3'd7
	} reg_idx_t;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 48;
	localparam int NORM_W = 36;
	localparam int ROT_FRAC = 28;
	localparam int MAT_W = 32;
	localparam logic signed [MAT_W-1:0] QUAT_ONE_Q28 = 32'sd268435456;
	localparam logic [1:0] CORNER_LAST = 2'd2;
endpackage

>>> hdl/trt_if.sv
// Valid/ready channel interfaces for the triangle transform block.
// Depends on trt_pkg.
interface trt_tri_if #(parameter int W = 16) (input logic clk);
	logic valid, ready;
	logic signed [W-1:0] first_x, first_y, first_z;
	logic signed [W-1:0] second_x, second_y, second_z;
	logic signed [W-1:0] third_x, third_y, third_z;
	modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		third_x, third_y, third_z, input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		third_x, third_y, third_z, output ready);
endinterface

interface trt_vtx_if #(parameter int W = 16) (input logic clk);
	import trt_pkg::*;
	logic valid, ready;
	logic signed [W-1:0] pos_x, pos_y, pos_z;
	logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
	logic [1:0] corner;
	logic clipped, last;
	modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, corner,
		clipped, last, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, corner,
		clipped, last, output ready);
endinterface

interface trt_cfg_if (input logic clk);
	import trt_pkg::*;
	logic valid, ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/trt_regs.sv
// Configuration register file and rotation matrix build.
// Depends on trt_pkg.
module trt_regs import trt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [CFG_IDX_W-1:0] wr_idx,
	input logic [CFG_DATA_W-1:0] wr_data,
	output logic signed [MAT_W-1:0] mat [3][3],
	output logic signed [15:0] off [3],
	output logic signed [15:0] scl [3]
);
	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [15:0] off_q [3];
	logic [47:0] scale_q;
	logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
	logic signed [MAT_W-1:0] mat_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= 16'sd16384;
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
			off_q <= '{default: '0};
			scale_q <= 48'h0100_0100_0100;
		end else if (wr_en && wr_idx[CFG_IDX_W-1:3] == '0) begin
			unique case (reg_idx_t'(wr_idx[2:0]))
				REG_QUAT_W: qw_q <= wr_data[15:0];
				REG_QUAT_X: qx_q <= wr_data[15:0];
				REG_QUAT_Y: qy_q <= wr_data[15:0];
				REG_QUAT_Z: qz_q <= wr_data[15:0];
				REG_OFFSET_X: off_q[0] <= wr_data[15:0];
				REG_OFFSET_Y: off_q[1] <= wr_data[15:0];
				REG_OFFSET_Z: off_q[2] <= wr_data[15:0];
				REG_SCALE: scale_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign xx = qx_q * qx_q;
	assign yy = qy_q * qy_q;
	assign zz = qz_q * qz_q;
	assign xy = qx_q * qy_q;
	assign xz = qx_q * qz_q;
	assign yz = qy_q * qz_q;
	assign wx = qw_q * qx_q;
	assign wy = qw_q * qy_q;
	assign wz = qw_q * qz_q;

	// matrix is registered from the quaternion registers and follows a write on the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '{'{QUAT_ONE_Q28, '0, '0}, '{'0, QUAT_ONE_Q28, '0},
				'{'0, '0, QUAT_ONE_Q28}};
		end else begin
			mat_q[0][0] <= QUAT_ONE_Q28 - ((yy + zz) <<< 1);
			mat_q[0][1] <= (xy - wz) <<< 1;
			mat_q[0][2] <= (xz + wy) <<< 1;
			mat_q[1][0] <= (xy + wz) <<< 1;
			mat_q[1][1] <= QUAT_ONE_Q28 - ((xx + zz) <<< 1);
			mat_q[1][2] <= (yz - wx) <<< 1;
			mat_q[2][0] <= (xz - wy) <<< 1;
			mat_q[2][1] <= (yz + wx) <<< 1;
			mat_q[2][2] <= QUAT_ONE_Q28 - ((xx + yy) <<< 1);
		end
	end

	always_comb begin
		mat = mat_q;
		off = off_q;
		scl[0] = scale_q[15:0];
		scl[1] = scale_q[31:16];
		scl[2] = scale_q[47:32];
	end
endmodule

>>> hdl/trt_seq.sv
// Triangle intake and corner sequencer: computes the face normal, then issues
// one vertex per cycle while adv is high. Depends on trt_pkg.
module trt_seq import trt_pkg::*; #(parameter int CW = 16) (
	input logic clk,
	input logic arst_n,
	trt_tri_if.sink tri_in,
	input logic adv,
	output logic vld_o,
	output logic signed [CW-1:0] v_o [3],
	output logic [1:0] corner_o,
	output logic signed [NORM_W-1:0] nrm_o [3]
);
	logic busy_q;
	logic [1:0] corner_q;
	logic signed [CW-1:0] vtx_q [3][3];
	logic signed [CW:0] e0 [3], e1 [3];
	logic signed [2*CW+3:0] n_full [3];
	logic take;

	assign tri_in.ready = !busy_q || (adv && corner_q == CORNER_LAST);
	assign take = tri_in.valid && tri_in.ready;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e0[i] = {vtx_q[1][i][CW-1], vtx_q[1][i]} - {vtx_q[0][i][CW-1], vtx_q[0][i]};
			e1[i] = {vtx_q[2][i][CW-1], vtx_q[2][i]} - {vtx_q[0][i][CW-1], vtx_q[0][i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			corner_q <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			corner_q <= '0;
		end else if (adv && busy_q) begin
			if (corner_q == CORNER_LAST) busy_q <= 1'b0;
			corner_q <= corner_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			vtx_q[0] <= '{tri_in.first_x, tri_in.first_y, tri_in.first_z};
			vtx_q[1] <= '{tri_in.second_x, tri_in.second_y, tri_in.second_z};
			vtx_q[2] <= '{tri_in.third_x, tri_in.third_y, tri_in.third_z};
		end
	end

	// normal is stable while the three corners are issued
	always_comb begin
		n_full[0] = e0[1] * e1[2] - e0[2] * e1[1];
		n_full[1] = e0[2] * e1[0] - e0[0] * e1[2];
		n_full[2] = e0[0] * e1[1] - e0[1] * e1[0];
		for (int i = 0; i < 3; i++) nrm_o[i] = NORM_W'(n_full[i]);
	end

	assign vld_o = busy_q;
	assign corner_o = corner_q;
	always_comb begin
		unique case (corner_q)
			2'd0: v_o = vtx_q[0];
			2'd1: v_o = vtx_q[1];
			default: v_o = vtx_q[2];
		endcase
	end
endmodule

>>> hdl/trt_xform.sv
// Vertex transform pipeline: scale, rotate, translate and saturate, four stages
// with stall. Depends on trt_pkg and the assertion macros.
`include "triangle_rigid_transform_top_macros.svh"
module trt_xform import trt_pkg::*; #(parameter int CW = 16, parameter int CF = 8) (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	output logic adv,
	input logic signed [CW-1:0] v_i [3],
	input logic [1:0] corner_i,
	input logic signed [NORM_W-1:0] nrm_i [3],
	input logic signed [MAT_W-1:0] mat [3][3],
	input logic signed [15:0] off [3],
	input logic signed [15:0] scl [3],
	trt_vtx_if.source vo
);
	localparam int SW = CW + 17;
	localparam int PW = SW + MAT_W;
	localparam logic signed [63:0] HI = (64'sd1 <<< (CW - 1)) - 1;
	localparam logic signed [63:0] LO = -(64'sd1 <<< (CW - 1));

	logic v1_s1, v1_s2, v1_s3, v1_s4;
	logic en1, en2, en3, en4;
	logic [1:0] c_s1, c_s2, c_s3, c_s4;
	logic signed [NORM_W-1:0] n_s1 [3], n_s2 [3], n_s3 [3], n_s4 [3];
	logic signed [CW+16:0] prod_s1 [3];
	logic signed [SW-1:0] sv_s2 [3];
	logic signed [63:0] pp_s3 [3][3];
	logic signed [CW-1:0] pos_s4 [3];
	logic clip_s4;
	logic signed [63:0] acc [3], r [3];
	logic signed [SW-1:0] rnd [3];
	logic hit [3];
	logic signed [CW-1:0] pos_n [3];
	logic mid_pop;

	assign en4 = !v1_s4 || vo.ready;
	assign en3 = !v1_s3 || en4;
	assign en2 = !v1_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign adv = en1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = SW'((prod_s1[i] + (CF == 0 ? 0 : (1 <<< (CF - 1)))) >>> CF);
			acc[i] = pp_s3[i][0] + pp_s3[i][1] + pp_s3[i][2];
			r[i] = ((acc[i] + (64'sd1 <<< (ROT_FRAC - 1))) >>> ROT_FRAC) + 64'(off[i]);
			hit[i] = (r[i] > HI) || (r[i] < LO);
			pos_n[i] = (r[i] > HI) ? CW'(HI) : (r[i] < LO) ? CW'(LO) : CW'(r[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v1_s2 <= 1'b0;
			v1_s3 <= 1'b0;
			v1_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= in_vld;
			if (en2) v1_s2 <= v1_s1;
			if (en3) v1_s3 <= v1_s2;
			if (en4) v1_s4 <= v1_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			c_s1 <= corner_i;
			n_s1 <= nrm_i;
			for (int i = 0; i < 3; i++) prod_s1[i] <= scl[i] * v_i[i];
		end
		if (en2) begin
			c_s2 <= c_s1;
			n_s2 <= n_s1;
			sv_s2 <= rnd;
		end
		if (en3) begin
			c_s3 <= c_s2;
			n_s3 <= n_s2;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) pp_s3[i][j] <= 64'(mat[i][j] * sv_s2[j]);
		end
		if (en4) begin
			c_s4 <= c_s3;
			n_s4 <= n_s3;
			pos_s4 <= pos_n;
			clip_s4 <= hit[0] || hit[1] || hit[2];
		end
	end

	assign vo.valid = v1_s4;
	assign vo.pos_x = pos_s4[0];
	assign vo.pos_y = pos_s4[1];
	assign vo.pos_z = pos_s4[2];
	assign vo.norm_x = n_s4[0];
	assign vo.norm_y = n_s4[1];
	assign vo.norm_z = n_s4[2];
	assign vo.corner = c_s4;
	assign vo.clipped = clip_s4;
	assign vo.last = (c_s4 == CORNER_LAST);

	assign mid_pop = vo.valid && vo.ready && c_s4 != CORNER_LAST && v1_s3;

	`TRT_ASSERT_IMP(a_stall_hold, clk, arst_n, vo.valid && !vo.ready, !en4)
	`TRT_ASSERT_NEXT(a_corner_step, clk, arst_n, mid_pop, vo.corner == $past(c_s4) + 2'd1)
	`TRT_ASSERT_IMP(a_corner_range, clk, arst_n, vo.valid, vo.corner != 2'd3)
endmodule

>>> hdl/triangle_rigid_transform_top.sv
// Top level of the triangle transform block.
// Depends on trt_pkg, trt_if, trt_regs, trt_seq, trt_xform.
//  channel  dir  content
//  tri      in   nine Q7.8 coordinates, one triangle
//  vtx      out  position, normal, corner, clipped, last
//  cfg      in   register index and data
// Triangle rate is set by the single vertex output, three vertices per triangle; the next
// triangle is taken as the last corner issues. Vertices pass sequencer, then stages s1-s4.
// Async reset restores identity rotation, unit scale, zero offset.
// Output stalls hold the pipeline; nothing is dropped or repeated.
module triangle_rigid_transform_top import trt_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int COORD_FRAC = 8
) (
	input logic clk,
	input logic arst_n,
	trt_tri_if.sink tri_in,
	trt_vtx_if.source vtx_out,
	trt_cfg_if.sink cfg
);
	logic signed [MAT_W-1:0] mat [3][3];
	logic signed [15:0] off [3], scl [3];
	logic adv, vld;
	logic signed [COORD_WIDTH-1:0] v [3];
	logic [1:0] corner;
	logic signed [NORM_W-1:0] nrm [3];

	assign cfg.ready = 1'b1;

	trt_regs u_regs (.clk, .arst_n, .wr_en(cfg.valid), .wr_idx(cfg.index),
		.wr_data(cfg.data), .mat, .off, .scl);
	trt_seq #(.CW(COORD_WIDTH)) u_seq (.clk, .arst_n, .tri_in, .adv, .vld_o(vld),
		.v_o(v), .corner_o(corner), .nrm_o(nrm));
	trt_xform #(.CW(COORD_WIDTH), .CF(COORD_FRAC)) u_xf (.clk, .arst_n, .in_vld(vld), .adv,
		.v_i(v), .corner_i(corner), .nrm_i(nrm), .mat, .off, .scl, .vo(vtx_out));
endmodule

>>> dv/trt_tb_scoreboard.sv
// Scoreboard for the triangle transform testbench: predicts the three vertices per triangle.
// Depends on trt_pkg; used by tb_top.
import trt_pkg::*;

typedef struct {
	logic signed [15:0] c[3][3];
} triangle_t;

typedef struct {
	logic signed [15:0] px, py, pz;
	logic signed [35:0] nx, ny, nz;
	logic [1:0] corner;
	logic clipped, last;
} vertex_t;

class trt_scoreboard;
	logic signed [15:0] quat[4];
	logic signed [15:0] offset[3];
	logic [47:0] scale;
	vertex_t pending_vertices[$];
	int errors;
	int vertices_seen;

	function new();
		quat = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
		offset = '{16'sd0, 16'sd0, 16'sd0};
		scale = 48'h0100_0100_0100;
		errors = 0;
		vertices_seen = 0;
	endfunction

	function void write_reg(reg_idx_t idx, logic [47:0] val);
		case (idx)
			REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z: quat[int'(idx)] = val[15:0];
			REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z: offset[int'(idx) - 4] = val[15:0];
			REG_SCALE: scale = val;
			default: ;
		endcase
	endfunction

	// floor division by 2^sh after adding half
	function longint rnd(longint v, int sh);
		longint t;
		t = v + (64'sd1 <<< (sh - 1));
		return t >>> sh;
	endfunction

	function void note_triangle(triangle_t t);
		longint vv[3][3], mat[3][3], e0[3], e1[3], nrm[3], sv[3];
		longint w, x, y, z, acc, r;
		vertex_t o;
		w = quat[0]; x = quat[1]; y = quat[2]; z = quat[3];
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++)
				vv[k][i] = t.c[k][i];
		for (int i = 0; i < 3; i++) begin
			e0[i] = vv[1][i] - vv[0][i];
			e1[i] = vv[2][i] - vv[0][i];
		end
		nrm[0] = e0[1] * e1[2] - e0[2] * e1[1];
		nrm[1] = e0[2] * e1[0] - e0[0] * e1[2];
		nrm[2] = e0[0] * e1[1] - e0[1] * e1[0];
		mat[0][0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
		mat[0][1] = 2 * (x * y - w * z);
		mat[0][2] = 2 * (x * z + w * y);
		mat[1][0] = 2 * (x * y + w * z);
		mat[1][1] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
		mat[1][2] = 2 * (y * z - w * x);
		mat[2][0] = 2 * (x * z - w * y);
		mat[2][1] = 2 * (y * z + w * x);
		mat[2][2] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
		for (int k = 0; k < 3; k++) begin
			logic signed [15:0] p[3];
			o.clipped = 0;
			for (int i = 0; i < 3; i++)
				sv[i] = rnd(longint'($signed(scale[16*i +: 16])) * vv[k][i], 8);
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++)
					acc += mat[i][j] * sv[j];
				r = rnd(acc, 28) + longint'(offset[i]);
				if (r > 32767) begin
					r = 32767; o.clipped = 1;
				end else if (r < -32768) begin
					r = -32768; o.clipped = 1;
				end
				p[i] = r[15:0];
			end
			o.px = p[0]; o.py = p[1]; o.pz = p[2];
			o.nx = nrm[0][35:0]; o.ny = nrm[1][35:0]; o.nz = nrm[2][35:0];
			o.corner = k[1:0];
			o.last = (k[1:0] == CORNER_LAST);
			pending_vertices = {pending_vertices, o};
		end
	endfunction

	function void check_vertex(vertex_t a);
		vertex_t e;
		vertices_seen++;
		if (pending_vertices.size() == 0) begin
			$display("%0t: unexpected vertex corner %0d", $time, a.corner);
			errors++;
			return;
		end
		e = pending_vertices.pop_front();
		if (a.px !== e.px || a.py !== e.py || a.pz !== e.pz) begin
			$display("%0t: pos exp %0d %0d %0d act %0d %0d %0d", $time,
				e.px, e.py, e.pz, a.px, a.py, a.pz);
			errors++;
		end
		if (a.nx !== e.nx || a.ny !== e.ny || a.nz !== e.nz) begin
			$display("%0t: norm exp %0d %0d %0d act %0d %0d %0d", $time,
				e.nx, e.ny, e.nz, a.nx, a.ny, a.nz);
			errors++;
		end
		if (a.corner !== e.corner || a.clipped !== e.clipped || a.last !== e.last) begin
			$display("%0t: corner/clipped/last exp %0d %0d %0d act %0d %0d %0d", $time,
				e.corner, e.clipped, e.last, a.corner, a.clipped, a.last);
			errors++;
		end
	endfunction
endclass

>>> dv/tb_top.sv
// Top of the triangle transform testbench: clock, reset, drivers, monitor, watchdog.
// Depends on trt_pkg, trt_if, trt_tb_scoreboard and the RTL top.
module tb_top;
	import trt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	trt_tri_if #(16) tri_ch (clk);
	trt_vtx_if #(16) vtx_ch (clk);
	trt_cfg_if cfg_ch (clk);

	triangle_rigid_transform_top dut (
		.clk(clk), .arst_n(arst_n), .tri_in(tri_ch.sink), .vtx_out(vtx_ch.source),
		.cfg(cfg_ch.sink)
	);

	trt_scoreboard sb = new();
	int idle_pct_in = 35;
	int idle_pct_out = 35;
	bit hold_out = 0;
	int triangles_sent = 0;
	int idle_cycles = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		tri_ch.valid = 0;
		vtx_ch.ready = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		{tri_ch.first_x, tri_ch.first_y, tri_ch.first_z} = '0;
		{tri_ch.second_x, tri_ch.second_y, tri_ch.second_z} = '0;
		{tri_ch.third_x, tri_ch.third_y, tri_ch.third_z} = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n = 1;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n || hold_out)
			vtx_ch.ready <= 0;
		else
			vtx_ch.ready <= ($urandom_range(99) >= idle_pct_out);
	end

	always @(posedge clk) begin
		vertex_t a;
		if (arst_n && vtx_ch.valid && vtx_ch.ready) begin
			a.px = vtx_ch.pos_x; a.py = vtx_ch.pos_y; a.pz = vtx_ch.pos_z;
			a.nx = vtx_ch.norm_x; a.ny = vtx_ch.norm_y; a.nz = vtx_ch.norm_z;
			a.corner = vtx_ch.corner; a.clipped = vtx_ch.clipped; a.last = vtx_ch.last;
			sb.check_vertex(a);
		end
	end

	always @(posedge clk) begin
		if ((tri_ch.valid && tri_ch.ready) || (vtx_ch.valid && vtx_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("watchdog: no progress");
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_triangle(triangle_t t);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct_in)
			@(negedge clk);
		tri_ch.valid <= 1;
		tri_ch.first_x <= t.c[0][0]; tri_ch.first_y <= t.c[0][1]; tri_ch.first_z <= t.c[0][2];
		tri_ch.second_x <= t.c[1][0]; tri_ch.second_y <= t.c[1][1];
		tri_ch.second_z <= t.c[1][2];
		tri_ch.third_x <= t.c[2][0]; tri_ch.third_y <= t.c[2][1]; tri_ch.third_z <= t.c[2][2];
		do @(posedge clk); while (!tri_ch.ready);
		sb.note_triangle(t);
		triangles_sent++;
		@(negedge clk);
		tri_ch.valid <= 0;
	endtask

	task automatic write_cfg(reg_idx_t idx, logic [47:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1;
		cfg_ch.index <= CFG_IDX_W'(idx);
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_ch.valid <= 0;
	endtask

	task automatic drain();
		while (sb.pending_vertices.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rnd_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(2047)) - 1024);
			default: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	function automatic triangle_t rnd_triangle();
		triangle_t t;
		int mode;
		mode = ($urandom_range(9) < 6) ? 1 : (($urandom_range(9) < 8) ? 0 : 2);
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++)
				t.c[k][i] = rnd_coord(mode);
		if ($urandom_range(19) == 0)
			t.c[2] = t.c[$urandom_range(1)];
		return t;
	endfunction

	task automatic set_transform(logic signed [15:0] w, x, y, z,
			logic signed [15:0] ox, oy, oz, logic [47:0] s);
		write_cfg(REG_QUAT_W, {32'h0, w});
		write_cfg(REG_QUAT_X, {32'h0, x});
		write_cfg(REG_QUAT_Y, {32'h0, y});
		write_cfg(REG_QUAT_Z, {32'h0, z});
		write_cfg(REG_OFFSET_X, {32'h0, ox});
		write_cfg(REG_OFFSET_Y, {32'h0, oy});
		write_cfg(REG_OFFSET_Z, {32'h0, oz});
		write_cfg(REG_SCALE, s);
	endtask

	initial begin
		triangle_t t;
		logic signed [15:0] q[4];
		wait (arst_n);
		repeat (2) @(posedge clk);

		// directed: reset transform, extremes, degenerate shapes
		t.c = '{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, '{16'sh8000, 16'sh8000, 16'sh8000},
			'{16'sh7fff, 16'sh8000, 16'sh0000}};
		send_triangle(t);
		t.c = '{'{16'sh8000, 16'sh7fff, 16'sh8000}, '{16'sh7fff, 16'sh8000, 16'sh7fff},
			'{16'sh8000, 16'sh8000, 16'sh7fff}};
		send_triangle(t);
		t.c = '{'{16'sd0, 16'sd0, 16'sd0}, '{16'sd256, 16'sd0, 16'sd0},
			'{16'sd0, 16'sd256, 16'sd0}};
		send_triangle(t);
		t.c = '{'{16'sd5, 16'sd5, 16'sd5}, '{16'sd5, 16'sd5, 16'sd5},
			'{16'sd5, 16'sd5, 16'sd5}};
		send_triangle(t);
		t.c = '{'{16'sd0, 16'sd0, 16'sd0}, '{16'sd100, 16'sd200, 16'sd300},
			'{16'sd200, 16'sd400, 16'sd600}};
		send_triangle(t);
		drain();
		// 90 degrees about z, offset extremes, negative scale, rounding halves
		set_transform(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'sh7fff, 16'sh8000, 16'sd1,
			{16'sh8000, 16'sh0080, 16'sh7fff});
		for (int i = 0; i < 5; i++)
			send_triangle(rnd_triangle());
		drain();
		// non-unit quaternion at the extremes
		set_transform(16'sh4000, 16'shc000, 16'sh4000, 16'shc000, 16'sd0, 16'sd0, 16'sd0,
			48'hffff_0001_0100);
		for (int i = 0; i < 5; i++)
			send_triangle(rnd_triangle());
		drain();
		set_transform(-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
			48'h0100_0100_0100);
		for (int i = 0; i < 4; i++)
			send_triangle(rnd_triangle());
		drain();

		// back-pressure: receiver holds off while the sender keeps offering
		hold_out = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_out = 0;
			end
			for (int i = 0; i < 20; i++)
				send_triangle(rnd_triangle());
		join
		drain();

		// random phases with random transforms; one phase with no idling
		for (int ph = 0; ph < 9; ph++) begin
			for (int i = 0; i < 4; i++)
				q[i] = ($urandom_range(3) == 0) ? 16'($urandom_range(32768) - 16384)
					: 16'($urandom_range(16384) - 8192);
			set_transform(q[0], q[1], q[2], q[3], 16'($urandom), 16'($urandom),
				16'($urandom), ($urandom_range(1)) ? {16'($urandom), 32'($urandom)}
				: {16'($urandom_range(512)), 16'($urandom_range(512)),
				16'($urandom_range(512))});
			if (ph == 4) begin
				idle_pct_in = 0; idle_pct_out = 0;
			end else begin
				idle_pct_in = 35; idle_pct_out = 35;
			end
			for (int i = 0; i < 48; i++)
				send_triangle(rnd_triangle());
			drain();
		end
		write_cfg(REG_SCALE, 48'h0100_0100_0100);
		for (int i = 0; i < 5; i++)
			send_triangle(rnd_triangle());
		drain();

		$display("Covered %0d triangles, %0d vertices, across several transforms",
			triangles_sent, sb.vertices_seen);
		$display("including extreme quaternions, offsets, scales and a long output stall.");
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

>>> files.f
+incdir+hdl
hdl/trt_pkg.sv
hdl/trt_if.sv
hdl/trt_regs.sv
hdl/trt_seq.sv
hdl/trt_xform.sv
hdl/triangle_rigid_transform_top.sv
dv/trt_tb_scoreboard.sv
dv/tb_top.sv
